// ----- rtl/i2c_clock_divider_search_macros.svh -----
// Assertion macros shared by the clock divider search design.
`ifndef I2C_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define I2C_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define ICDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define ICDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/icds_pkg.sv -----
// Shared constants, types and helper functions for the clock divider search.
package icds_pkg;

  localparam int CLK_W     = 30;
  localparam int TARGET_W  = 32;
  localparam int M_W       = 4;
  localparam int N_W       = 3;
  localparam int WORD_W    = M_W + N_W;
  localparam int DIVISOR_W = 8;
  localparam int NUM_M     = 2 ** M_W;

  localparam int DIV_STEP = 10;

  localparam logic [M_W-1:0]   M_LAST = M_W'(NUM_M - 1);
  localparam logic [N_W-1:0]   N_LAST = N_W'((2 ** N_W) - 1);
  localparam logic [M_W-1:0]   DEF_M  = M_W'(5);
  localparam logic [N_W-1:0]   DEF_N  = N_W'(0);
  localparam logic [CLK_W-1:0] SRC_CLK_RESET = CLK_W'(600000000);

  typedef struct packed {
    logic busy;
    logic done;
  } icds_div_stat_t;

  // First-stage divisor for a given m: ten times (m + 1).
  function automatic logic [DIVISOR_W-1:0] icds_divisor(input logic [M_W-1:0] m);
    return DIVISOR_W'(DIV_STEP * (int'(m) + 1));
  endfunction

endpackage

// ----- rtl/i2c_clock_divider_search.sv -----
// Top level of the two-wire bus clock divider search.
// One target rate in, one divider pair out. The block first divides the source clock by
// 10*(m+1) for all sixteen m values on a shared one-bit-per-cycle divider, then steps
// through the n-outer, m-inner pairs at one pair per cycle, taking the shifted quotient
// as the candidate rate, until an exact match or the last pair. Input is not taken
// during a search; a finished result waits in the output register, and the next input is
// accepted while it does. The configuration register is read throughout a search, so it
// should be written only while no search is in flight.
`include "i2c_clock_divider_search_macros.svh"

module i2c_clock_divider_search
  import icds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // target_rate_hz[31:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // divider_m[3:0], divider_n[6:4],
                                       // clock_control_word[13:7], zero[15:14]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data   // source_clock_hz[29:0]
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                state;
  logic [CLK_W-1:0]      source_clk;
  logic [TARGET_W-1:0]   target;
  logic [M_W-1:0]        m_idx;
  logic [N_W-1:0]        n_idx;
  logic [CLK_W-1:0]      quot_q [NUM_M];
  logic                  have;
  logic [TARGET_W-1:0]   best;
  logic [M_W-1:0]        best_m;
  logic [N_W-1:0]        best_n;
  logic [M_W-1:0]        res_m;
  logic [N_W-1:0]        res_n;

  logic                  in_xfer;
  logic                  div_start;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [CLK_W-1:0]      div_quotient;
  icds_div_stat_t        div_stat;

  logic [CLK_W-1:0]      freq;
  logic [TARGET_W:0]     diff;
  logic                  upd;
  logic                  hit;
  logic                  last_pair;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Start the next quotient as soon as the previous one lands.
  assign div_start   = in_xfer ||
                       ((state == ST_DIV) && div_stat.done && (m_idx != M_LAST));
  assign div_divisor = in_xfer ? icds_divisor('0) : icds_divisor(m_idx + M_W'(1));

  icds_div #(
    .DIVIDEND_W (CLK_W),
    .DIVISOR_BW (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (source_clk),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_stat)
  );

  // Dividing by 2^n after the first stage gives the same floor as the combined divisor.
  assign freq      = quot_q[m_idx] >> n_idx;
  assign diff      = {1'b0, target} - {{(TARGET_W - CLK_W + 1){1'b0}}, freq};
  assign upd       = !diff[TARGET_W] && (!have || (diff[TARGET_W-1:0] < best));
  assign hit       = upd && (diff[TARGET_W-1:0] == '0);
  assign last_pair = (m_idx == M_LAST) && (n_idx == N_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_clk <= SRC_CLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      source_clk <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      have     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_DIV;
            have  <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_stat.done && (m_idx == M_LAST)) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (upd) begin
            have <= 1'b1;
          end
          if (hit || last_pair) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          target <= s_tdata;
          m_idx  <= '0;
          n_idx  <= '0;
          best   <= '0;
          best_m <= DEF_M;
          best_n <= DEF_N;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          quot_q[m_idx] <= div_quotient;
          m_idx         <= m_idx + M_W'(1);
        end
      end
      ST_CMP: begin
        if (upd) begin
          best   <= diff[TARGET_W-1:0];
          best_m <= m_idx;
          best_n <= n_idx;
        end
        m_idx <= m_idx + M_W'(1);
        if (m_idx == M_LAST) begin
          n_idx <= n_idx + N_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_m <= best_m;
          res_n <= best_n;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {{(16 - M_W - N_W - WORD_W){1'b0}}, res_m, res_n, res_n, res_m};

  `ICDS_ASSERT_IMP(a_busy_blocks_input, div_stat.busy, !s_tready, "input ready during division")
  `ICDS_ASSERT_IMP(a_done_only_in_div, div_stat.done, state == ST_DIV, "divider done outside division phase")
  `ICDS_ASSERT_NXT(a_accept_starts_div, in_xfer, div_stat.busy && (state == ST_DIV), "accepted item did not start division")
  `ICDS_ASSERT_IMP(a_cmp_divider_idle, state == ST_CMP, !div_stat.busy, "divider busy during compare phase")

endmodule

// ----- rtl/icds_div.sv -----
// Restoring serial divider: one quotient bit per clock cycle.
module icds_div
  import icds_pkg::*;
#(
  parameter int DIVIDEND_W = CLK_W,
  parameter int DIVISOR_BW = DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_BW-1:0] divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output icds_div_stat_t        status
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_BW-1:0] rem;
  logic [DIVISOR_BW-1:0] dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_BW:0]   trial;
  logic [DIVISOR_BW:0]   diff;
  logic                  fits;

  // The shifted remainder is below twice the divisor, so one subtract decides the bit.
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(DIVIDEND_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(DIVIDEND_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_BW-1:0] : trial[DIVISOR_BW-1:0];
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule
